// File: hw/rtl/rth_pkg.sv
// rth_pkg: shared types and constants for the rgb to hsv pixel converter
// used by rth_div_stage and rgb_to_hsv_converter; depends on nothing else
package rth_pkg;

    // both long divisions run over a 24 bit dividend, four bits per stage
    localparam int DIV_W          = 24;
    localparam int DIV_BITS_STAGE = 4;
    localparam int DIV_STAGES     = DIV_W / DIV_BITS_STAGE;

    // hue sector offsets and the full turn, in whole degrees
    localparam int HUE_OFF_GREEN_DEG = 120;
    localparam int HUE_OFF_BLUE_DEG  = 240;
    localparam int HUE_TURN_DEG      = 360;
    localparam int HUE_SLOPE_DEG     = 60;

    typedef enum logic [1:0] {
        SECTOR_RED   = 2'd0,
        SECTOR_GREEN = 2'd1,
        SECTOR_BLUE  = 2'd2
    } sector_t;

    // restoring divider state: partial remainder, dividend shifting out as
    // the quotient shifts in, and the divisor
    typedef struct packed {
        logic [7:0]       rem;
        logic [DIV_W-1:0] nq;
        logic [7:0]       den;
    } div_state_t;

    typedef struct packed {
        div_state_t hue_div;
        div_state_t sat_div;
        logic       hue_neg;
        sector_t    sector;
        logic       gray;
        logic       black;
        logic [7:0] value;
    } pix_item_t;

endpackage

// File: hw/rtl/rgb_to_hsv_converter.sv
// rgb_to_hsv_converter: streaming rgb to hsv pixel converter, top level
// depends on rth_pkg and rth_div_stage
//
//  port group  dir  tdata fields (lowest bit up)
//  s_          in   red_in[7:0], green_in[7:0], blue_in[7:0]
//  m_          out  hue_out[HUE_FRAC_BITS+8:0], saturation_out[16:0], value_out[7:0]
//
//  one pixel per clock sustained unless m_tready stalls; prep register, then DIV_STAGES
//  stages of the 24 bit restoring dividers, 4 quotient bits per stage, then the output
//  register; each stage holds its beat while the next is full and fills bubbles
//  aresetn clears only the valid bits; no state survives between pixels
module rgb_to_hsv_converter #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
    output logic        m_tvalid,
    input  logic        m_tready,
    // hue_out, saturation_out, value_out, zero padded
    output logic [((HUE_FRAC_BITS + 34 + 7) / 8) * 8 - 1:0] m_tdata
);
    import rth_pkg::*;

    localparam int HUE_W   = HUE_FRAC_BITS + 9;
    localparam int OUT_W   = HUE_W + 17 + 8;
    localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [HUE_W:0] OFF_GREEN = (HUE_W + 1)'(HUE_OFF_GREEN_DEG << HUE_FRAC_BITS);
    localparam logic [HUE_W:0] OFF_BLUE  = (HUE_W + 1)'(HUE_OFF_BLUE_DEG << HUE_FRAC_BITS);
    localparam logic [HUE_W:0] TURN      = (HUE_W + 1)'(HUE_TURN_DEG << HUE_FRAC_BITS);

    // ---------------- prep stage: max, min, sector, numerators
    logic [7:0]  red, green, blue;
    logic [7:0]  hi, lo, span, mag, ch_a, ch_b;
    logic [8:0]  diff;
    logic [13:0] slope_prod;
    pix_item_t   prep_next;
    logic        prep_valid_reg;
    pix_item_t   prep_item_reg;

    assign red   = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign blue  = s_tdata[23:16];

    always_comb begin
        hi = red;
        lo = red;
        if (green > hi) hi = green;
        if (blue > hi)  hi = blue;
        if (green < lo) lo = green;
        if (blue < lo)  lo = blue;
        span = hi - lo;

        prep_next.sector = SECTOR_BLUE;
        ch_a = red;
        ch_b = green;
        if (hi == red) begin
            prep_next.sector = SECTOR_RED;
            ch_a = green;
            ch_b = blue;
        end else if (hi == green) begin
            prep_next.sector = SECTOR_GREEN;
            ch_a = blue;
            ch_b = red;
        end

        diff       = {1'b0, ch_a} - {1'b0, ch_b};
        mag        = diff[8] ? 8'(-diff) : diff[7:0];
        slope_prod = 14'({6'b0, mag} * 14'(HUE_SLOPE_DEG));

        prep_next.hue_div.rem = '0;
        prep_next.hue_div.nq  = DIV_W'(slope_prod) << HUE_FRAC_BITS;
        prep_next.hue_div.den = span;
        prep_next.sat_div.rem = '0;
        prep_next.sat_div.nq  = {span, 16'b0};
        prep_next.sat_div.den = hi;
        prep_next.hue_neg     = diff[8];
        prep_next.gray        = (span == 8'd0);
        prep_next.black       = (hi == 8'd0);
        prep_next.value       = hi;
    end

    logic      pipe_valid [DIV_STAGES+1];
    logic      pipe_ready [DIV_STAGES+1];
    pix_item_t pipe_item  [DIV_STAGES+1];

    assign s_tready = !prep_valid_reg || pipe_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (s_tready) begin
            prep_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            prep_item_reg <= prep_next;
        end
    end

    assign pipe_valid[0] = prep_valid_reg;
    assign pipe_item[0]  = prep_item_reg;

    // ---------------- divider stages
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        rth_div_stage u_div_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (pipe_valid[k]),
            .in_ready  (pipe_ready[k]),
            .in_item   (pipe_item[k]),
            .out_valid (pipe_valid[k+1]),
            .out_ready (pipe_ready[k+1]),
            .out_item  (pipe_item[k+1])
        );
    end

    // ---------------- output stage: sector offset, wrap, pack
    pix_item_t        fin;
    logic [HUE_W:0]   quot, offset, hue_wide;
    logic [HUE_W-1:0] hue_next, hue_reg;
    logic [16:0]      sat_next, sat_reg;
    logic [7:0]       value_reg;
    logic             out_valid_reg;

    assign fin = pipe_item[DIV_STAGES];
    assign pipe_ready[DIV_STAGES] = !out_valid_reg || m_tready;

    always_comb begin
        quot = fin.hue_div.nq[HUE_W:0];
        unique case (fin.sector)
            SECTOR_RED:   offset = '0;
            SECTOR_GREEN: offset = OFF_GREEN;
            SECTOR_BLUE:  offset = OFF_BLUE;
            default:      offset = '0;
        endcase
        if (!fin.hue_neg) begin
            hue_wide = offset + quot;
        end else if (quot > offset) begin
            // negative angle wraps once round the circle
            hue_wide = offset + TURN - quot;
        end else begin
            hue_wide = offset - quot;
        end
        hue_next = fin.gray ? '0 : hue_wide[HUE_W-1:0];
        sat_next = fin.black ? '0 : fin.sat_div.nq[16:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_ready[DIV_STAGES]) begin
            out_valid_reg <= pipe_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_ready[DIV_STAGES] && pipe_valid[DIV_STAGES]) begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            value_reg <= fin.value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({value_reg, sat_reg, hue_reg});

`ifndef SYNTHESIS
    // black pixel never carries saturation
    a_black_sat : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && value_reg == 8'd0) |-> (sat_reg == 17'd0))
        else $error("saturation set on a black pixel");

    // hue stays below one full turn
    a_hue_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, hue_reg} < TURN))
        else $error("hue beyond 360 degrees");

    // zero saturation only for gray, and gray has no hue
    a_gray_hue : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && sat_reg == 17'd0) |-> (hue_reg == '0))
        else $error("hue on a pixel with no saturation");

    // saturation never exceeds one
    a_sat_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (sat_reg <= 17'h10000))
        else $error("saturation above one");
`endif

endmodule

// File: hw/rtl/rth_div_stage.sv
// rth_div_stage: one registered stage of the two restoring dividers
// (hue and saturation), with its own valid bit and bubble-filling ready
// depends on rth_pkg
module rth_div_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  rth_pkg::pix_item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output rth_pkg::pix_item_t out_item
);
    import rth_pkg::*;

    logic      valid_reg;
    pix_item_t item_reg;
    pix_item_t item_next;

    function automatic div_state_t div_step(input div_state_t d);
        logic [8:0] sh;
        div_state_t r;
        r    = d;
        sh   = {d.rem, d.nq[DIV_W-1]};
        r.nq = {d.nq[DIV_W-2:0], 1'b0};
        if (sh >= {1'b0, d.den}) begin
            r.rem   = 8'(sh - {1'b0, d.den});
            r.nq[0] = 1'b1;
        end else begin
            r.rem = sh[7:0];
        end
        return r;
    endfunction

    always_comb begin
        item_next = in_item;
        for (int i = 0; i < DIV_BITS_STAGE; i++) begin
            item_next.hue_div = div_step(item_next.hue_div);
            item_next.sat_div = div_step(item_next.sat_div);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule
